// ----- src/edd_pkg.sv -----
// Shared constants and width helpers for the Euclidean distance unit.
package edd_pkg;

    // Default coordinate width in bits (signed Q8.8 coordinates).
    localparam int COORD_WIDTH_DEF = 16;

    // The square-root radicand width. A sum of three squares needs 2*cw+2 bits.
    // It is capped at 64 bits, and the sum saturates at that cap.
    function automatic int rad_width(input int cw);
        int full_w;
        full_w = 2 * cw + 2;
        return (full_w > 64) ? 64 : full_w;
    endfunction

endpackage

// ----- src/euclidean_distance_2d_3d_unit.sv -----
// Throughput: one transaction per cycle unless the output stalls; the differences, the squares
// and the sum take one register stage each, and the floor square root resolves one bit per stage.
// A stall at the output backs up through every full stage in the same cycle.
// Reset clears only the stage valid bits; the data registers are not reset.
// Top level: Euclidean distance of two points in 2D or 3D, floor of the exact root.
module euclidean_distance_2d_3d_unit #(
    parameter int COORD_WIDTH = edd_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] az,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by_coord,
    input  logic signed [COORD_WIDTH-1:0] bz,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [COORD_WIDTH:0]          distance
);

    localparam int CW     = COORD_WIDTH;
    localparam int DW     = COORD_WIDTH + 1;
    localparam int SQ_W   = 2 * COORD_WIDTH;
    localparam int SUM_W  = 2 * COORD_WIDTH + 2;
    localparam int RAD_W  = edd_pkg::rad_width(COORD_WIDTH);
    localparam int ROOT_W = RAD_W / 2;

    // Stage 1: difference magnitudes.
    logic signed [CW:0] dx, dy, dz;
    logic [CW-1:0]      magx_next, magy_next, magz_next;
    logic               v1_reg;
    logic [CW-1:0]      magx_reg, magy_reg, magz_reg;
    logic               rdy1;

    // Stage 2: squares.
    logic [SQ_W-1:0]    sqx_next, sqy_next, sqz_next;
    logic               v2_reg;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg, sqz_reg;
    logic               rdy2;

    // Stage 3: sum, saturated to the radicand width.
    logic [SUM_W-1:0]   sum_next;
    logic [RAD_W-1:0]   rad_next;
    logic               v3_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic               rdy3;

    logic               sqrt_ready;
    logic [ROOT_W-1:0]  root;

    always_comb
    begin
        dx = $signed({bx[CW-1], bx}) - $signed({ax[CW-1], ax});
        dy = $signed({by_coord[CW-1], by_coord}) - $signed({ay[CW-1], ay});
        dz = $signed({bz[CW-1], bz}) - $signed({az[CW-1], az});
        magx_next = dx[CW] ? CW'(-dx) : dx[CW-1:0];
        magy_next = dy[CW] ? CW'(-dy) : dy[CW-1:0];
        // In 2D the z term drops out of the sum.
        if (kind)
        begin
            magz_next = dz[CW] ? CW'(-dz) : dz[CW-1:0];
        end
        else
        begin
            magz_next = '0;
        end
    end

    assign rdy1     = !v1_reg || rdy2;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy3     = !v3_reg || sqrt_ready;
    assign in_ready = rdy1;

    always_comb
    begin
        sqx_next = SQ_W'(magx_reg) * SQ_W'(magx_reg);
        sqy_next = SQ_W'(magy_reg) * SQ_W'(magy_reg);
        sqz_next = SQ_W'(magz_reg) * SQ_W'(magz_reg);
        sum_next = SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
    end

    generate
        if (SUM_W > RAD_W)
        begin : g_sat
            assign rad_next = (|sum_next[SUM_W-1:RAD_W]) ? {RAD_W{1'b1}} : sum_next[RAD_W-1:0];
        end
        else
        begin : g_nosat
            assign rad_next = sum_next[RAD_W-1:0];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            magx_reg <= magx_next;
            magy_reg <= magy_next;
            magz_reg <= magz_next;
        end
        if (rdy2 && v1_reg)
        begin
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            sqz_reg <= sqz_next;
        end
        if (rdy3 && v2_reg)
        begin
            rad_reg <= rad_next;
        end
    end

    edd_sqrt_pipe #(
        .RAD_WIDTH (RAD_W)
    ) u_sqrt (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (v3_reg),
        .in_ready    (sqrt_ready),
        .in_radicand (rad_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_root    (root)
    );

    assign distance = DW'(root);

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v1_reg)
        else $error("accepted transaction did not enter the pipeline");

    a_square_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !rdy3 |=> v2_reg && $stable(sqx_reg) && $stable(sqz_reg))
        else $error("stalled square stage changed");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> v1_reg && v2_reg && v3_reg && out_valid)
        else $error("input stalled while a stage is empty");

endmodule

// ----- src/edd_sqrt_pipe.sv -----
// Pipelined floor square root that resolves one root bit per register stage.
module edd_sqrt_pipe #(
    parameter int RAD_WIDTH = edd_pkg::rad_width(edd_pkg::COORD_WIDTH_DEF)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [RAD_WIDTH-1:0]   in_radicand,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [RAD_WIDTH/2-1:0] out_root
);

    localparam int ROOT_W = RAD_WIDTH / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic                 valid_reg [ROOT_W];
    logic [RAD_WIDTH-1:0] rad_reg   [ROOT_W];
    logic [REM_W-1:0]     rem_reg   [ROOT_W];
    logic [ROOT_W-1:0]    root_reg  [ROOT_W];
    logic [ROOT_W:0]      stage_ready;

    assign stage_ready[ROOT_W] = out_ready;
    assign in_ready            = stage_ready[0];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_stage
            logic                 v_prev;
            logic [RAD_WIDTH-1:0] rad_prev;
            logic [REM_W-1:0]     rem_prev;
            logic [ROOT_W-1:0]    root_prev;
            logic [REM_W-1:0]     rem_sh;
            logic [REM_W-1:0]     trial;
            logic                 take;
            logic [RAD_WIDTH-1:0] rad_next;
            logic [REM_W-1:0]     rem_next;
            logic [ROOT_W-1:0]    root_next;

            if (k == 0)
            begin : g_first
                assign v_prev    = in_valid;
                assign rad_prev  = in_radicand;
                assign rem_prev  = '0;
                assign root_prev = '0;
            end
            else
            begin : g_next
                assign v_prev    = valid_reg[k-1];
                assign rad_prev  = rad_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
            end

            assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];

            // Bring down the next two radicand bits and try the next root bit.
            // The remainder never exceeds twice the partial root, so its low
            // ROOT_W bits hold it whole before the shift.
            always_comb
            begin
                rem_sh    = {rem_prev[ROOT_W-1:0], rad_prev[RAD_WIDTH-1 -: 2]};
                trial     = {root_prev, 2'b01};
                take      = (rem_sh >= trial);
                rem_next  = take ? (rem_sh - trial) : rem_sh;
                root_next = {root_prev[ROOT_W-2:0], take};
                rad_next  = {rad_prev[RAD_WIDTH-3:0], 2'b00};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (stage_ready[k])
                begin
                    valid_reg[k] <= v_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[k] && v_prev)
                begin
                    rad_reg[k]  <= rad_next;
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];

    // A finished root leaves a remainder of at most twice the root.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ROOT_W-1] |-> (rem_reg[ROOT_W-1] <= {1'b0, root_reg[ROOT_W-1], 1'b0}))
        else $error("square root remainder exceeds bound");

    a_first_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] && !stage_ready[1] |=>
            valid_reg[0] && $stable(root_reg[0]) && $stable(rad_reg[0]))
        else $error("stalled first root stage changed");

    a_full_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("root pipeline stalls with a free slot");

endmodule

// ----- sim/tb_euclidean_distance_2d_3d_unit.sv -----
// Self-checking testbench for the 2D/3D Euclidean distance unit with a distance scoreboard.

class distance_scoreboard;

    logic [edd_pkg::COORD_WIDTH_DEF:0] expected_dist_q[$];
    int                                errors;

    function new();
        errors = 0;
    endfunction

    // Floor square root found one result bit at a time, from the top down.
    function automatic logic [edd_pkg::COORD_WIDTH_DEF:0] floor_root(logic [63:0] radicand);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = edd_pkg::COORD_WIDTH_DEF; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        return root[edd_pkg::COORD_WIDTH_DEF:0];
    endfunction

    function automatic logic [63:0] axis_square(logic signed [edd_pkg::COORD_WIDTH_DEF-1:0] a,
                                                logic signed [edd_pkg::COORD_WIDTH_DEF-1:0] b);
        longint delta;
        delta = longint'(b) - longint'(a);
        return 64'(delta * delta);
    endfunction

    // Called for every accepted input transaction.
    function void note_input(logic kind,
                             logic signed [edd_pkg::COORD_WIDTH_DEF-1:0] ax, ay, az,
                             logic signed [edd_pkg::COORD_WIDTH_DEF-1:0] bx, by, bz);
        logic [63:0] sum_sq;
        sum_sq = axis_square(ax, bx) + axis_square(ay, by);
        if (kind)
            sum_sq = sum_sq + axis_square(az, bz);
        expected_dist_q.push_back(floor_root(sum_sq));
    endfunction

    // Called for every accepted output transaction.
    function void check_result(logic [edd_pkg::COORD_WIDTH_DEF:0] got);
        logic [edd_pkg::COORD_WIDTH_DEF:0] want;
        if (expected_dist_q.size() == 0)
        begin
            $error("distance: result %0d arrived with no transaction outstanding", got);
            errors++;
        end
        else
        begin
            want = expected_dist_q.pop_front();
            if (got !== want)
            begin
                $error("distance mismatch: expected %0d, actual %0d", want, got);
                errors++;
            end
        end
    endfunction

    function int pending();
        return expected_dist_q.size();
    endfunction

endclass

module tb_euclidean_distance_2d_3d_unit;

    localparam int CW = edd_pkg::COORD_WIDTH_DEF;
    localparam int N_RANDOM = 1700;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 kind;
    logic signed [CW-1:0] ax, ay, az, bx, by_coord, bz;
    logic                 out_valid;
    logic                 out_ready;
    logic [CW:0]          distance;

    distance_scoreboard dist_sb;
    int                 burst_items_left;

    euclidean_distance_2d_3d_unit #(
        .COORD_WIDTH(CW)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .ax       (ax),
        .ay       (ay),
        .az       (az),
        .bx       (bx),
        .by_coord (by_coord),
        .bz       (bz),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .distance (distance)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [CW-1:0] edge_coord();
        case ($urandom_range(0, 6))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            5: return 16'sd32766;
            default: return 16'sd32767;
        endcase
    endfunction

    // Caller stands at a falling edge; returns at the falling edge after the handshake.
    task automatic send_point_pair(input logic k,
                                   input logic signed [CW-1:0] pax, pay, paz,
                                   input logic signed [CW-1:0] pbx, pby, pbz);
        int gap;
        gap = 0;
        if (burst_items_left > 0)
            burst_items_left--;
        else if ($urandom_range(0, 99) < 3)
            burst_items_left = $urandom_range(20, 80);
        else
            gap = idle_len();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind     = k;
        ax       = pax;
        ay       = pay;
        az       = paz;
        bx       = pbx;
        by_coord = pby;
        bz       = pbz;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_pair();
        logic                 k;
        logic signed [CW-1:0] c[6];
        int                   shape;
        k = 1'($urandom);
        shape = $urandom_range(0, 9);
        for (int i = 0; i < 6; i++)
        begin
            if (shape < 5)
                c[i] = CW'($urandom);
            else if (shape < 7)
                c[i] = edge_coord();
            else if (i < 3)
                c[i] = CW'($urandom);
            else
                // Second point close to the first one, so small distances show up too.
                c[i] = c[i-3] + CW'($urandom_range(0, 64)) - CW'(32);
        end
        send_point_pair(k, c[0], c[1], c[2], c[3], c[4], c[5]);
    endtask

    // Result side: ready level held for a random number of cycles.
    initial
    begin
        int hold;
        hold = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if ($urandom_range(0, 1) == 1)
            begin
                out_ready = 1'b1;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                    : $urandom_range(0, 8);
            end
            else
            begin
                out_ready = 1'b0;
                hold = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                dist_sb.note_input(kind, ax, ay, az, bx, by_coord, bz);
            if (out_valid && out_ready)
                dist_sb.check_result(distance);
        end
    end

    initial
    begin
        int guard;
        dist_sb = new();
        burst_items_left = 0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        kind     = 1'b0;
        ax       = '0;
        ay       = '0;
        az       = '0;
        bx       = '0;
        by_coord = '0;
        bz       = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Origin and equal points give zero.
        send_point_pair(1'b0, 0, 0, 0, 0, 0, 0);
        send_point_pair(1'b1, 0, 0, 0, 0, 0, 0);
        send_point_pair(1'b1, 1234, -567, 89, 1234, -567, 89);
        send_point_pair(1'b0, -32768, 32767, -32768, -32768, 32767, 32767);
        // Largest differences on every axis, both directions.
        send_point_pair(1'b0, -32768, 32767, 100, 32767, -32768, -100);
        send_point_pair(1'b1, -32768, -32768, -32768, 32767, 32767, 32767);
        send_point_pair(1'b1, 32767, 32767, 32767, -32768, -32768, -32768);
        send_point_pair(1'b0, 32767, -32768, 0, -32768, 32767, 0);
        // The z coordinates count only in 3D.
        send_point_pair(1'b0, 0, 0, -32768, 0, 0, 32767);
        send_point_pair(1'b1, 0, 0, -32768, 0, 0, 32767);
        send_point_pair(1'b0, 5, 5, 32767, 5, 5, -32768);
        // Exact roots and sums just off a square, which must round down.
        send_point_pair(1'b0, 0, 0, 0, 3, 4, 0);
        send_point_pair(1'b1, 0, 0, 0, 2, 2, 4);
        send_point_pair(1'b0, 0, 0, 0, 3, 2, 0);
        send_point_pair(1'b1, 0, 0, 0, 1, 1, 1);
        send_point_pair(1'b1, 0, 0, 0, 256, 256, 256);
        send_point_pair(1'b1, 10, 20, 30, 10, 20, 31);
        send_point_pair(1'b0, -1, 0, 0, 0, 0, 0);
        send_point_pair(1'b0, 0, -1, 0, 0, 0, 0);
        send_point_pair(1'b1, -256, -256, -256, 256, 256, 256);
        send_point_pair(1'b0, 16'sh5555, 16'shAAAA, 0, 16'shAAAA, 16'sh5555, 0);

        for (int n = 0; n < N_RANDOM; n++)
            send_random_pair();
        in_valid = 1'b0;

        guard = 0;
        while (dist_sb.pending() != 0 && guard < 200_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (30) @(posedge clk);
        if (dist_sb.pending() != 0)
        begin
            $error("distance: %0d transactions never produced a result", dist_sb.pending());
            dist_sb.errors++;
        end

        if (dist_sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/edd_pkg.sv
src/edd_sqrt_pipe.sv
src/euclidean_distance_2d_3d_unit.sv
sim/tb_euclidean_distance_2d_3d_unit.sv
